@@ rtl/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the gap tolerant run chainer: field widths,
// table geometry, command queue geometry and the register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grc_pkg;

  // Table and field geometry
  localparam int NUM_SEQUENCES  = 64;
  localparam int COORD_BITS     = 40;
  localparam int SEQ_BITS       = 6;
  localparam int GAP_BITS       = 32;
  localparam int SEQ_IDX_BITS   = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int SEQ_RANGE_BITS = SEQ_BITS + 1;
  localparam int CMP_BITS       = (COORD_BITS + 1 > GAP_BITS) ? COORD_BITS + 1 : GAP_BITS;

  localparam logic [COORD_BITS-1:0] COORD_MAX       = '1;
  localparam logic [GAP_BITS-1:0]   GAP_LIMIT_RESET = GAP_BITS'(1000);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register map: register index sits at paddr[2]
  localparam int   APB_ADDR_BITS = 3;
  localparam int   APB_DATA_BITS = 32;
  localparam logic REG_GAP_LIMIT = 1'b0;

  typedef enum logic {
    OP_RUN   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // One table entry
  typedef struct packed {
    logic [COORD_BITS-1:0] column_start;
    logic [COORD_BITS-1:0] span;
    logic [COORD_BITS-1:0] target_start;
    logic                  forward;
  } chain_t;

  localparam int CHAIN_BITS = $bits(chain_t);

  // Classified command handed from front to back
  typedef struct packed {
    logic                    is_flush;
    logic [SEQ_IDX_BITS-1:0] idx;
    logic [COORD_BITS-1:0]   col;
    logic [COORD_BITS-1:0]   len;
    logic [COORD_BITS-1:0]   tgt;
    logic                    fwd;
    logic [COORD_BITS:0]     col_end;
    logic [COORD_BITS:0]     tgt_end;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

@@ rtl/gap_tolerant_run_chainer_top.sv @@
// ----------------------------------------------------------------------------
// gap_tolerant_run_chainer_top
// Keeps one open alignment chain per target sequence, extends it with runs
// whose strand matches and whose column and target gaps stay within gap_limit, and emits chains.
//
// An item is taken on start while busy is low; busy rises only when the
// two-entry command queue is full. A run that opens a chain is written to the
// table as it leaves the queue. A run that meets an open chain passes through
// the table read, the edge sums and the gap test with write-back; the
// registered table read and the split of the edge sums from the gap test
// keep these steps apart. A flush leaves the queue and then sweeps the table
// in index order, checking each entry in S_SCAN and emitting each open one in
// S_FEMIT, stopping at the last open one. Each chain appears on out_* for
// one cycle with out_valid high and must be taken then; there is no
// backpressure. Open flags are flip-flops cleared by reset, so no table
// clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_tolerant_run_chainer_top import grc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Item channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [SEQ_BITS-1:0]      in_sequence_index,
  input  logic [COORD_BITS-1:0]    in_column_start,
  input  logic [COORD_BITS-1:0]    in_span_length,
  input  logic [COORD_BITS-1:0]    in_target_start,
  input  logic                     in_forward_strand,
  // Result channel
  output logic                     out_valid,
  output logic [SEQ_BITS-1:0]      out_sequence,
  output logic [COORD_BITS-1:0]    out_column_start,
  output logic [COORD_BITS-1:0]    out_span,
  output logic [COORD_BITS-1:0]    out_target_start,
  output logic                     out_forward,
  output logic                     out_last_of_flush,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [GAP_BITS-1:0] gap_limit_r;
  logic                cfg_wr;
  logic                pop;
  queue_head_t         head;

  // Register write on the access phase of a transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GAP_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RESET;
    end else if (cfg_wr) begin
      gap_limit_r <= pwdata[GAP_BITS-1:0];
    end
  end

  // Register read
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GAP_LIMIT) begin
      prdata = APB_DATA_BITS'(gap_limit_r);
    end
  end

  grc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_sequence_index (in_sequence_index),
    .in_column_start   (in_column_start),
    .in_span_length    (in_span_length),
    .in_target_start   (in_target_start),
    .in_forward_strand (in_forward_strand),
    .pop               (pop),
    .head              (head)
  );

  grc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .gap_limit         (gap_limit_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_sequence      (out_sequence),
    .out_column_start  (out_column_start),
    .out_span          (out_span),
    .out_target_start  (out_target_start),
    .out_forward       (out_forward),
    .out_last_of_flush (out_last_of_flush)
  );

endmodule

@@ rtl/grc_ram.sv @@
// ----------------------------------------------------------------------------
// grc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/grc_front.sv @@
// ----------------------------------------------------------------------------
// grc_front
// Accepts items, drops runs for sequences beyond the table, precomputes run
// end coordinates and queues commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grc_front import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic [SEQ_BITS-1:0]   in_sequence_index,
  input  logic [COORD_BITS-1:0] in_column_start,
  input  logic [COORD_BITS-1:0] in_span_length,
  input  logic [COORD_BITS-1:0] in_target_start,
  input  logic                  in_forward_strand,
  input  logic                  pop,
  output queue_head_t           head
);

  cmd_t                 q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  cmd_t                 in_cmd;
  logic                 is_flush;
  logic                 in_range;
  logic                 push;

  // Classify the incoming item
  assign is_flush = (in_operation == OP_FLUSH);
  assign in_range = ({1'b0, in_sequence_index} < SEQ_RANGE_BITS'(NUM_SEQUENCES));

  always_comb begin
    in_cmd          = '0;
    in_cmd.is_flush = is_flush;
    in_cmd.idx      = in_sequence_index[SEQ_IDX_BITS-1:0];
    in_cmd.col      = in_column_start;
    in_cmd.len      = in_span_length;
    in_cmd.tgt      = in_target_start;
    in_cmd.fwd      = in_forward_strand;
    in_cmd.col_end  = {1'b0, in_column_start} + {1'b0, in_span_length};
    in_cmd.tgt_end  = {1'b0, in_target_start} + {1'b0, in_span_length};
  end

  assign busy = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign push = start && !busy && (is_flush || in_range);

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

@@ rtl/grc_back.sv @@
// ----------------------------------------------------------------------------
// grc_back
// Chain table and sequencer: a write of one entry per run, read first when
// its chain is open, and an ordered sweep over open entries for a flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grc_back import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [GAP_BITS-1:0]   gap_limit,
  input  queue_head_t           head,
  output logic                  pop,
  output logic                  out_valid,
  output logic [SEQ_BITS-1:0]   out_sequence,
  output logic [COORD_BITS-1:0] out_column_start,
  output logic [COORD_BITS-1:0] out_span,
  output logic [COORD_BITS-1:0] out_target_start,
  output logic                  out_forward,
  output logic                  out_last_of_flush
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_FEMIT
  } state_t;

  state_t                   state_r;
  cmd_t                     cmd_r;
  chain_t                   chain_r;
  logic [COORD_BITS:0]      col_edge_r;
  logic [COORD_BITS:0]      t_later_r;
  logic [COORD_BITS:0]      t_edge_r;
  logic [COORD_BITS:0]      span_raw_r;
  logic [SEQ_IDX_BITS-1:0]  scan_idx_r;
  logic [NUM_SEQUENCES-1:0] open_r;

  logic                     out_valid_r;
  logic [SEQ_BITS-1:0]      out_sequence_r;
  chain_t                   out_chain_r;
  logic                     out_last_r;

  logic                     ram_we;
  logic [SEQ_IDX_BITS-1:0]  ram_waddr;
  chain_t                   ram_wdata;
  logic [SEQ_IDX_BITS-1:0]  ram_raddr;
  chain_t                   ram_rd;

  logic                     head_opens;
  logic                     col_ok;
  logic                     tgt_ok;
  logic                     merge;
  logic [COORD_BITS-1:0]    span_sat;
  logic [NUM_SEQUENCES-1:0] scan_bit;
  logic                     emit_last;
  logic                     scan_end;

  // Gap passes when not negative and no larger than the limit
  function automatic logic gap_pass(input logic [COORD_BITS:0] later,
                                    input logic [COORD_BITS:0] edge_v,
                                    input logic [GAP_BITS-1:0] limit);
    logic [COORD_BITS:0] diff;
    diff = later - edge_v;
    return (later >= edge_v) && (CMP_BITS'(diff) <= CMP_BITS'(limit));
  endfunction

  grc_ram #(
    .WIDTH (CHAIN_BITS),
    .DEPTH (NUM_SEQUENCES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd)
  );

  // Merge decision from the registered edges
  assign col_ok   = gap_pass({1'b0, cmd_r.col}, col_edge_r, gap_limit);
  assign tgt_ok   = gap_pass(t_later_r, t_edge_r, gap_limit);
  assign merge    = (chain_r.forward == cmd_r.fwd) && col_ok && tgt_ok;
  assign span_sat = (span_raw_r > {1'b0, COORD_MAX}) ? COORD_MAX
                                                     : span_raw_r[COORD_BITS-1:0];

  // Flush sweep bookkeeping
  assign scan_bit  = NUM_SEQUENCES'(1) << scan_idx_r;
  assign emit_last = ((open_r & ~scan_bit) == '0);
  assign scan_end  = (scan_idx_r == SEQ_IDX_BITS'(NUM_SEQUENCES - 1));

  assign pop        = (state_r == S_IDLE) && head.valid;
  assign head_opens = pop && !head.cmd.is_flush && !open_r[head.cmd.idx];
  assign ram_raddr  = (state_r == S_SCAN) ? scan_idx_r : head.cmd.idx;

  // Table write port: open a fresh chain, or write back a merge or restart
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head.cmd.idx;
    ram_wdata = '{column_start: head.cmd.col, span: head.cmd.len,
                  target_start: head.cmd.tgt, forward: head.cmd.fwd};
    if (head_opens) begin
      ram_we = 1'b1;
    end else if (state_r == S_EVAL) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_r.idx;
      if (merge) begin
        ram_wdata = '{column_start: chain_r.column_start, span: span_sat,
                      target_start: cmd_r.fwd ? chain_r.target_start : cmd_r.tgt,
                      forward: chain_r.forward};
      end else begin
        ram_wdata = '{column_start: cmd_r.col, span: cmd_r.len,
                      target_start: cmd_r.tgt, forward: cmd_r.fwd};
      end
    end
  end

  // Sequencer state, open flags and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r <= head.cmd;
            if (head.cmd.is_flush) begin
              scan_idx_r <= '0;
              if (open_r != '0) begin
                state_r <= S_SCAN;
              end
            end else if (open_r[head.cmd.idx]) begin
              state_r <= S_READ;
            end else begin
              open_r[head.cmd.idx] <= 1'b1;
            end
          end
        end
        S_READ: begin
          // Latch the entry and form the edge sums
          chain_r    <= ram_rd;
          col_edge_r <= {1'b0, ram_rd.column_start} + {1'b0, ram_rd.span};
          span_raw_r <= cmd_r.col_end - {1'b0, ram_rd.column_start};
          if (cmd_r.fwd) begin
            t_later_r <= {1'b0, cmd_r.tgt};
            t_edge_r  <= {1'b0, ram_rd.target_start} + {1'b0, ram_rd.span};
          end else begin
            t_later_r <= {1'b0, ram_rd.target_start};
            t_edge_r  <= cmd_r.tgt_end;
          end
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          // Emit the old chain when the run cannot extend it
          if (!merge) begin
            out_valid_r    <= 1'b1;
            out_sequence_r <= SEQ_BITS'(cmd_r.idx);
            out_chain_r    <= chain_r;
            out_last_r     <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (open_r[scan_idx_r]) begin
            state_r <= S_FEMIT;
          end else if (scan_end) begin
            state_r <= S_IDLE;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        S_FEMIT: begin
          out_valid_r            <= 1'b1;
          out_sequence_r         <= SEQ_BITS'(scan_idx_r);
          out_chain_r            <= ram_rd;
          out_last_r             <= emit_last;
          open_r[scan_idx_r]     <= 1'b0;
          if (emit_last || scan_end) begin
            state_r <= S_IDLE;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
            state_r    <= S_SCAN;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sequence      = out_sequence_r;
  assign out_column_start  = out_chain_r.column_start;
  assign out_span          = out_chain_r.span;
  assign out_target_start  = out_chain_r.target_start;
  assign out_forward       = out_chain_r.forward;
  assign out_last_of_flush = out_last_r;

  // A result only follows a gap test or a flush read
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EVAL || state_r == S_FEMIT))
    else $error("result strobe without a producing state");

  // A table read for a run only happens on an open chain
  a_read_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> open_r[cmd_r.idx])
    else $error("run read of a closed chain");

  // The final flush result leaves the table empty
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEMIT && emit_last) |=> (open_r == '0))
    else $error("open chains left after last flush result");

  // The sweep runs only while some chain is still open
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (open_r != '0))
    else $error("flush sweep over an empty table");

endmodule
